### sv/sus_pkg.sv
// Shared types and constants for the sorted unique set union core.
// Used by sus_ctrl, sus_datapath and sorted_unique_set_union_core.
`default_nettype none

package sus_pkg;

  localparam int STORE_DEPTH = 32;
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);

  typedef struct packed {
    logic signed [31:0] value;
    logic               final_item;
  } sus_in_t;

  typedef struct packed {
    logic signed [31:0] union_value;
    logic               last_of_run;
    logic               overflowed;
  } sus_out_t;

  // controller to datapath
  typedef struct packed {
    logic insert;
    logic pop;
    logic clear_ovf;
  } sus_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } sus_status_t;

endpackage

`default_nettype wire

### sv/sorted_unique_set_union_core.sv
// Top level of the sorted unique set union core.
// Depends on sus_pkg, sus_ctrl and sus_datapath.
`default_nettype none

// An item is transferred when start is high and busy is low; after a non-final
// item the next one may follow at once, since every held value is compared
// against the new one in parallel and the insert is a shift of the cell row.
// The final item is absorbed like the others, then the union drains from the
// head cell one value per cycle, with busy high throughout; strobe marks each
// result for exactly one cycle and the receiver must take it then. The store
// and the overflow flag are empty again once the value marked last_of_run has
// been shown.
module sorted_unique_set_union_core
  import sus_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  sus_in_t  item,
  output logic     strobe,
  output sus_out_t result
);

  sus_cmd_t    cmd;
  sus_status_t status;

  sus_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .final_item (item.final_item),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy),
    .strobe     (strobe)
  );

  sus_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .value  (item.value),
    .status (status),
    .result (result)
  );

  // a final transfer always starts a run on the next cycle
  a_final_starts_run: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.final_item |=> strobe)
    else $error("final transfer did not start a run");

  // a run continues without gaps until the last value
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_of_run |=> strobe)
    else $error("gap inside result run");

  // the last value ends the run and frees the block
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_of_run |=> !busy && !strobe)
    else $error("run did not end after last value");

  // overflow flag is the same on every value of a run
  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_of_run |=> $stable(result.overflowed))
    else $error("overflow flag changed within a run");

endmodule

`default_nettype wire

### sv/sus_ctrl.sv
// Controller for the set union core: absorbs items while idle, then drains the run.
// Depends on sus_pkg.
`default_nettype none

module sus_ctrl
  import sus_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        final_item,
  input  sus_status_t status,
  output sus_cmd_t    cmd,
  output logic        busy,
  output logic        strobe
);

  typedef enum logic {
    IDLE,
    EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (start && final_item) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (status.last) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.insert    = (state == IDLE) && start;
    cmd.pop       = (state == EMIT);
    cmd.clear_ovf = (state == EMIT) && status.last;
  end

  assign busy   = (state == EMIT);
  assign strobe = (state == EMIT);

endmodule

`default_nettype wire

### sv/sus_datapath.sv
// Datapath: a row of sorted cells with parallel compare, insert-by-shift and drain.
// Depends on sus_pkg.
`default_nettype none

module sus_datapath
  import sus_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  sus_cmd_t           cmd,
  input  logic signed [31:0] value,
  output sus_status_t        status,
  output sus_out_t           result
);

  logic signed [31:0] cells      [STORE_DEPTH];
  logic signed [31:0] cells_next [STORE_DEPTH];
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               ovf;
  logic               ovf_next;

  logic [STORE_DEPTH-1:0] valid;
  logic [STORE_DEPTH-1:0] eq;
  logic [STORE_DEPTH-1:0] shift;
  logic                   dup;
  logic                   full;
  logic                   do_insert;

  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      valid[i] = COUNT_W'(i) < count;
      eq[i]    = valid[i] && (cells[i] == value);
      // empty cells act as +infinity so the new value lands right after the last
      shift[i] = !valid[i] || (cells[i] > value);
    end
    dup       = |eq;
    full      = (count == COUNT_W'(STORE_DEPTH));
    do_insert = cmd.insert && !dup && !full;
  end

  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      cells_next[i] = cells[i];
    end
    if (do_insert) begin
      cells_next[0] = shift[0] ? value : cells[0];
      for (int i = 1; i < STORE_DEPTH; i++) begin
        if (shift[i]) begin
          cells_next[i] = shift[i-1] ? cells[i-1] : value;
        end
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < STORE_DEPTH - 1; i++) begin
        cells_next[i] = cells[i+1];
      end
    end
  end

  always_comb begin
    count_next = count;
    ovf_next   = ovf;
    if (do_insert) begin
      count_next = count + COUNT_W'(1);
    end else if (cmd.pop) begin
      count_next = count - COUNT_W'(1);
    end
    if (cmd.insert && !dup && full) begin
      ovf_next = 1'b1;
    end else if (cmd.clear_ovf) begin
      ovf_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      cells[i] <= cells_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  assign status.last        = (count == COUNT_W'(1));
  assign result.union_value = cells[0];
  assign result.last_of_run = (count == COUNT_W'(1));
  assign result.overflowed  = ovf;

endmodule

`default_nettype wire
